// ===== hw/rtl/lbcc_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink and chase controller package
// Shared constants, operation codes and field layout of the input word.
// ----------------------------------------------------------------------------
package lbcc_pkg;

    // Default LED count and configuration reset values.
    localparam int NUM_LEDS_DEF        = 8;
    localparam logic [7:0] RST_STEP_TICKS = 8'd10;
    localparam logic [7:0] RST_RUN_SCALE  = 8'd100;
    localparam logic [15:0] RST_RUN_TICKS = 16'd10;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_SCALE  = 2'd1;

    // Input word layout, first field in the lowest bits.
    localparam int OP_LSB     = 0;
    localparam int NUM_LSB    = 2;
    localparam int LVL_LSB    = 6;
    localparam int PERIOD_LSB = 7;
    localparam int PAT_LSB    = 15;
    localparam int UNITS_LSB  = 18;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_BLINK = 2'd2,
        OP_CHASE = 2'd3
    } t_op;

    // Chase patterns; any other code means no chase.
    localparam logic [2:0] PAT_SINGLE_UP   = 3'd1;
    localparam logic [2:0] PAT_SINGLE_DOWN = 3'd2;
    localparam logic [2:0] PAT_DARK_UP     = 3'd3;
    localparam logic [2:0] PAT_DARK_DOWN   = 3'd4;
    localparam logic [2:0] PAT_NONE        = 3'd0;

endpackage

// ===== hw/rtl/led_blink_and_chase_controller.sv =====
// ----------------------------------------------------------------------------
// LED blink and chase controller
// Keeps the levels of NUM_LEDS LEDs: direct writes, per-LED blinking, timed
// chase patterns and a one-shot countdown that turns everything off.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Word contents
//  s_axis    in    op, led_number, level, blink_period, run_pattern, run_units
//  m_axis    out   led_levels after the input word
//  cfg       in    0 step_ticks, 1 run_tick_scale
//
//  On a tick due for a step, one shared increment and compare unit walks the
//  blink counters one LED a cycle, then the chase step, countdown and result
//  load follow. Other ticks run only the countdown, other words only the load.
//  s_axis_tready is high only in idle; the result register lets the next word
//  in while a result waits, and a stalled m_axis holds the last step.
//  Reset is synchronous, active low, clears all state but the result data and arms the countdown.
//
module led_blink_and_chase_controller #(
    parameter int NUM_LEDS = lbcc_pkg::NUM_LEDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input word, from bit 0: op[1:0], led_number[5:2], level[6],
    // blink_period[14:7], run_pattern[17:15], run_units[25:18], zero fill.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lbcc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Result word, from bit 0: led_levels[7:0].
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lbcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [lbcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbcc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import lbcc_pkg::*;

    localparam int IDX_W = $clog2(NUM_LEDS);
    localparam int POS_W = $clog2(NUM_LEDS + 1);
    localparam logic [POS_W-1:0] POS_N   = POS_W'(NUM_LEDS);
    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(NUM_LEDS - 1);
    localparam logic [3:0]       NUM_MAX = 4'(NUM_LEDS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_CHASE = 5'b00100,
        S_RUN   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                 r_state;
    logic [IDX_W-1:0]       r_idx;
    logic [NUM_LEDS-1:0]    r_led;
    logic                   r_blink_en  [NUM_LEDS];
    logic [7:0]             r_blink_cnt [NUM_LEDS];
    logic [7:0]             r_blink_lim [NUM_LEDS];
    logic [2:0]             r_mode;
    logic [POS_W-1:0]       r_pos;
    logic [7:0]             r_prescale;
    logic [15:0]            r_remain;
    logic                   r_armed;
    logic [7:0]             r_step_ticks;
    logic [7:0]             r_run_scale;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    // Input word fields.
    logic [1:0]  in_op;
    logic [3:0]  in_num;
    logic        in_lvl;
    logic [7:0]  in_period;
    logic [2:0]  in_pat;
    logic [7:0]  in_units;

    assign in_op     = s_axis_tdata[OP_LSB +: 2];
    assign in_num    = s_axis_tdata[NUM_LSB +: 4];
    assign in_lvl    = s_axis_tdata[LVL_LSB];
    assign in_period = s_axis_tdata[PERIOD_LSB +: 8];
    assign in_pat    = s_axis_tdata[PAT_LSB +: 3];
    assign in_units  = s_axis_tdata[UNITS_LSB +: 8];

    logic             in_accept;
    logic             num_ok;
    logic [IDX_W-1:0] num_idx;
    logic [3:0]       num_m1;
    logic [8:0]       pre_next;
    logic             step_due;
    logic             out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign num_ok    = (in_num != 4'd0) && (in_num <= NUM_MAX);
    assign num_m1    = in_num - 4'd1;
    assign num_idx   = num_m1[IDX_W-1:0];
    assign pre_next  = {1'b0, r_prescale} + 9'd1;
    assign step_due  = pre_next >= {1'b0, r_step_ticks};
    assign out_free  = !r_out_valid || m_axis_tready;

    // Shared blink unit: increment and compare the counter of the LED at r_idx.
    logic [7:0] walk_cnt;
    logic [7:0] walk_inc;
    logic       walk_hit;

    assign walk_cnt = r_blink_cnt[r_idx];
    assign walk_inc = walk_cnt + 8'd1;
    assign walk_hit = r_blink_en[r_idx] && (walk_cnt == r_blink_lim[r_idx]);

    // Chase step: each LED bit is worked out on its own from the position.
    logic [NUM_LEDS-1:0] n_chase_led;
    logic [POS_W-1:0]    n_chase_pos;
    logic [POS_W-1:0]    down_p;
    logic                mode_up;
    logic                mode_down;
    logic                mode_dark;

    assign mode_up   = (r_mode == PAT_SINGLE_UP) || (r_mode == PAT_DARK_UP);
    assign mode_down = (r_mode == PAT_SINGLE_DOWN) || (r_mode == PAT_DARK_DOWN);
    assign mode_dark = (r_mode == PAT_DARK_UP) || (r_mode == PAT_DARK_DOWN);
    assign down_p    = (r_pos == '0) ? POS_N : (r_pos - POS_W'(1));

    always_comb begin
        n_chase_led = r_led;
        n_chase_pos = r_pos;
        if (mode_up) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                n_chase_led[i] = mode_dark ? 1'b1 : r_led[i];
                if (r_pos == '0) begin
                    if (i == NUM_LEDS - 1) begin
                        n_chase_led[i] = 1'b0;
                    end
                end else if (POS_W'(i + 1) == r_pos) begin
                    n_chase_led[i] = 1'b1;
                end else if (POS_W'(i + 2) == r_pos) begin
                    n_chase_led[i] = 1'b0;
                end
            end
            n_chase_pos = (r_pos >= POS_N) ? '0 : (r_pos + POS_W'(1));
        end else if (mode_down) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                n_chase_led[i] = mode_dark ? 1'b1 : r_led[i];
                if (POS_W'(i + 1) == down_p) begin
                    n_chase_led[i] = 1'b1;
                end else if (POS_W'(i) == down_p) begin
                    n_chase_led[i] = 1'b0;
                end
            end
            n_chase_pos = down_p;
        end
    end

    // Countdown step.
    logic [15:0] n_remain;
    assign n_remain = (r_remain != 16'd0) ? (r_remain - 16'd1) : 16'd0;

    // Result word: low eight LEDs, zero above NUM_LEDS.
    logic [OUT_DATA_W-1:0] n_out_data;
    always_comb begin
        n_out_data = '0;
        for (int b = 0; b < OUT_DATA_W; b++) begin
            if (b < NUM_LEDS) begin
                n_out_data[b] = r_led[b];
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ticks <= RST_STEP_TICKS;
            r_run_scale  <= RST_RUN_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP_TICKS: r_step_ticks <= i_cfg_wdata;
                REG_RUN_SCALE:  r_run_scale  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer and LED state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_led      <= '0;
            r_mode     <= PAT_NONE;
            r_pos      <= '0;
            r_prescale <= '0;
            r_remain   <= RST_RUN_TICKS;
            r_armed    <= 1'b1;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_blink_en[i]  <= 1'b0;
                r_blink_cnt[i] <= '0;
                r_blink_lim[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (t_op'(in_op))
                            OP_TICK: begin
                                r_idx <= '0;
                                if (step_due) begin
                                    r_prescale <= '0;
                                    r_state    <= S_WALK;
                                end else begin
                                    r_prescale <= pre_next[7:0];
                                    r_state    <= S_RUN;
                                end
                            end
                            OP_SET: begin
                                if (num_ok) begin
                                    r_led[num_idx] <= in_lvl;
                                end
                                r_state <= S_DONE;
                            end
                            OP_BLINK: begin
                                if (num_ok) begin
                                    r_blink_en[num_idx]  <= in_lvl;
                                    r_blink_cnt[num_idx] <= '0;
                                    r_blink_lim[num_idx] <= in_period;
                                    r_led[num_idx]       <= in_lvl;
                                end
                                r_state <= S_DONE;
                            end
                            OP_CHASE: begin
                                r_pos    <= '0;
                                r_mode   <= in_pat;
                                r_remain <= 16'(in_units) * 16'(r_run_scale);
                                r_armed  <= 1'b1;
                                r_state  <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                // One LED's blink counter per cycle.
                S_WALK: begin
                    if (r_blink_en[r_idx]) begin
                        if (walk_hit) begin
                            r_led[r_idx]       <= ~r_led[r_idx];
                            r_blink_cnt[r_idx] <= '0;
                        end else begin
                            r_blink_cnt[r_idx] <= walk_inc;
                        end
                    end
                    if (r_idx == IDX_END) begin
                        r_state <= S_CHASE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_CHASE: begin
                    r_led   <= n_chase_led;
                    r_pos   <= n_chase_pos;
                    r_state <= S_RUN;
                end
                // Countdown after the step, so its end wins.
                S_RUN: begin
                    if (r_armed) begin
                        r_remain <= n_remain;
                        if (n_remain == 16'd0) begin
                            r_armed <= 1'b0;
                            r_mode  <= PAT_NONE;
                            r_led   <= '0;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_data <= n_out_data;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // An accepted word always starts the sequencer.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("sequencer stayed idle after accepting a word");

    // The countdown ending leaves every LED low.
    a_run_end_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_armed) |-> (r_led == '0) && (r_mode == PAT_NONE))
        else $error("countdown ended with LEDs lit or chase active");

    // The walk index and chase position stay within the LED count.
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= IDX_END))
        else $error("blink walk index out of range");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_N))
        else $error("chase position out of range");

endmodule
